// ===== hw/rtl/itse_pkg.sv =====
// ----------------------------------------------------------------------------
// itse_pkg: shared types and constants
// Payload structs, field widths, mode codes, register indexes and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itse_pkg;

    localparam int FORCE_W     = 16;
    localparam int SCALE_OUT_W = 16;
    localparam int STEP_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_TIME_W  = 24;
    localparam int MIN_SCALE_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd2;

    // Envelope kinds
    localparam logic KIND_IMPULSE = 1'b0;
    localparam logic KIND_RAMP    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMP_FORCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMP_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RISE      = 3'd6;

    // Register reset values
    localparam logic                   RST_KIND      = KIND_IMPULSE;
    localparam logic [FORCE_W-1:0]     RST_IMP_FORCE = 16'hEC00;
    localparam logic [CFG_TIME_W-1:0]  RST_IMP_LEN   = 24'd30000;
    localparam logic [MIN_SCALE_W-1:0] RST_MIN_SCALE = 16'd6554;
    localparam logic [CFG_TIME_W-1:0]  RST_FALL      = 24'd50000;
    localparam logic [CFG_TIME_W-1:0]  RST_HOLD      = 24'd200000;
    localparam logic [CFG_TIME_W-1:0]  RST_RISE      = 24'd200000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_z;
        logic [SCALE_OUT_W-1:0]    damping_scale;
        logic                      busy_res;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic eval;
        logic mul;
        logic div_start;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/itse_div.sv =====
// ----------------------------------------------------------------------------
// itse_div: restoring divider
// Unsigned divide, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits and that the divisor is nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itse_div #(
    parameter int QUO_W = 16,
    parameter int DEN_W = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QUO_W+DEN_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic [QUO_W-1:0]       quo,
    output logic                   done
);
    localparam int NUM_W = QUO_W + DEN_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // numerator's upper part is already below the divisor
            rem_next  = num[NUM_W-1:QUO_W];
            low_next  = num[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next = {low_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        cnt_reg <= cnt_next;
    end

    assign quo  = low_reg;
    assign done = !busy_reg;

endmodule

// ===== hw/rtl/itse_dp.sv =====
// ----------------------------------------------------------------------------
// itse_dp: envelope datapath
// Configuration registers, envelope state, segment decode, ramp multiply,
// divider and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itse_dp #(
    parameter int TIME_BITS       = 24,
    parameter int SCALE_FRAC_BITS = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [itse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  itse_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output itse_pkg::out_item_t              m_data,
    input  itse_pkg::dp_cmd_t                cmd,
    output itse_pkg::dp_status_t             status
);
    import itse_pkg::*;

    localparam int SW    = SCALE_FRAC_BITS + 1;
    localparam int EW    = TIME_BITS + 2;
    localparam int FH_W  = CFG_TIME_W + 1;
    localparam int FHR_W = CFG_TIME_W + 2;
    localparam int CW    = (EW > FHR_W) ? EW : FHR_W;
    localparam int ESW   = (SW > MIN_SCALE_W) ? SW : MIN_SCALE_W;
    localparam int NUM_W = SW + CFG_TIME_W;

    localparam logic [SW-1:0] SCALE_ONE   = {1'b1, {SCALE_FRAC_BITS{1'b0}}};
    localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};
    localparam logic [CFG_TIME_W-1:0] TIME_MASK = (TIME_BITS >= CFG_TIME_W) ?
        {CFG_TIME_W{1'b1}} : CFG_TIME_W'((64'd1 << TIME_BITS) - 64'd1);

    // configuration
    logic                         kind_reg;
    logic signed [FORCE_W-1:0]    imp_force_reg;
    logic [CFG_TIME_W-1:0]        imp_len_reg;
    logic [MIN_SCALE_W-1:0]       min_scale_reg;
    logic [CFG_TIME_W-1:0]        fall_reg;
    logic [CFG_TIME_W-1:0]        hold_reg;
    logic [CFG_TIME_W-1:0]        rise_reg;

    // values derived from configuration
    logic [FH_W-1:0]       fh_reg;
    logic [FHR_W-1:0]      fhr_reg;
    logic [SW-1:0]         lo_reg, lo_next;
    logic [SW-1:0]         d_reg;
    logic [CFG_TIME_W-1:0] rise_div_reg;

    // envelope state
    logic          running_reg, running_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;

    // current item
    logic [MODE_W-1:0] mode_reg;
    logic [STEP_W-1:0] dt_reg;

    // evaluation results
    logic signed [FORCE_W-1:0] force_res_reg, force_eval;
    logic [SW-1:0]             scale_res_reg, scale_eval;
    logic                      busy_res_reg, run_eval;
    logic                      need_div_reg, need_div_eval;
    logic [CFG_TIME_W-1:0]     mul_t_reg, mul_t_eval;
    logic [CFG_TIME_W-1:0]     den_reg, den_eval;
    logic [SW-1:0]             base_reg, base_eval;
    logic                      down_reg, down_eval;

    logic [NUM_W-1:0] prod_reg;
    logic [SW-1:0]    quo;
    logic             div_done;
    logic [SW-1:0]    scale_fin;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [EW:0]   sum;
    logic [EW-1:0] el_sat;
    logic [CW-1:0] t_cw;
    logic [CW-1:0] t_rise;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= RST_KIND;
            imp_force_reg <= RST_IMP_FORCE;
            imp_len_reg   <= RST_IMP_LEN;
            min_scale_reg <= RST_MIN_SCALE;
            fall_reg      <= RST_FALL;
            hold_reg      <= RST_HOLD;
            rise_reg      <= RST_RISE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KIND:      kind_reg      <= cfg_data[0];
                REG_IMP_FORCE: imp_force_reg <= cfg_data[FORCE_W-1:0];
                REG_IMP_LEN:   imp_len_reg   <= cfg_data[CFG_TIME_W-1:0] & TIME_MASK;
                REG_MIN_SCALE: min_scale_reg <= cfg_data[MIN_SCALE_W-1:0];
                REG_FALL:      fall_reg      <= cfg_data[CFG_TIME_W-1:0] & TIME_MASK;
                REG_HOLD:      hold_reg      <= cfg_data[CFG_TIME_W-1:0] & TIME_MASK;
                REG_RISE:      rise_reg      <= cfg_data[CFG_TIME_W-1:0] & TIME_MASK;
                default: begin
                end
            endcase
        end
    end

    // clamp min_scale to one
    assign lo_next = (ESW'(min_scale_reg) > ESW'(SCALE_ONE)) ?
                     SCALE_ONE : SW'(min_scale_reg);

    always_ff @(posedge aclk) begin
        fh_reg       <= FH_W'(fall_reg) + FH_W'(hold_reg);
        fhr_reg      <= FHR_W'(fh_reg) + FHR_W'(rise_reg);
        lo_reg       <= lo_next;
        d_reg        <= SCALE_ONE - lo_next;
        rise_div_reg <= (rise_reg == '0) ? CFG_TIME_W'(1) : rise_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_data.mode;
            dt_reg   <= s_data.time_step;
        end
    end

    // saturating time advance
    assign sum    = {1'b0, elapsed_reg} + (EW+1)'(dt_reg);
    assign el_sat = sum[EW] ? ELAPSED_MAX : sum[EW-1:0];

    // segment decode
    assign t_cw   = CW'(elapsed_reg);
    assign t_rise = t_cw - CW'(fh_reg);

    always_comb begin
        force_eval    = '0;
        scale_eval    = SCALE_ONE;
        run_eval      = running_reg;
        need_div_eval = 1'b0;
        mul_t_eval    = t_cw[CFG_TIME_W-1:0];
        den_eval      = fall_reg;
        base_eval     = SCALE_ONE;
        down_eval     = 1'b1;
        if (mode_reg == MODE_TICK && running_reg) begin
            if (kind_reg == KIND_IMPULSE) begin
                if (t_cw <= CW'(imp_len_reg)) begin
                    force_eval = imp_force_reg;
                end else begin
                    run_eval = 1'b0;
                end
            end else begin
                priority if (t_cw <= CW'(fall_reg)) begin
                    if (fall_reg <= CFG_TIME_W'(1)) begin
                        scale_eval = lo_reg;
                    end else begin
                        need_div_eval = 1'b1;
                    end
                end else if (t_cw <= CW'(fh_reg)) begin
                    scale_eval = lo_reg;
                end else if (t_cw <= CW'(fhr_reg)) begin
                    need_div_eval = 1'b1;
                    mul_t_eval    = t_rise[CFG_TIME_W-1:0];
                    den_eval      = rise_div_reg;
                    base_eval     = lo_reg;
                    down_eval     = 1'b0;
                end else begin
                    run_eval = 1'b0;
                end
            end
        end
    end

    always_comb begin
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        if (cmd.step) begin
            unique case (mode_reg)
                MODE_TRIGGER: begin
                    running_next = 1'b1;
                    elapsed_next = '0;
                end
                MODE_RESET: begin
                    running_next = 1'b0;
                    elapsed_next = '0;
                end
                MODE_TICK: begin
                    if (running_reg) begin
                        elapsed_next = el_sat;
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.eval) begin
            running_next = run_eval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            elapsed_reg <= '0;
        end else begin
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            force_res_reg <= force_eval;
            scale_res_reg <= scale_eval;
            busy_res_reg  <= run_eval;
            need_div_reg  <= need_div_eval;
            mul_t_reg     <= mul_t_eval;
            den_reg       <= den_eval;
            base_reg      <= base_eval;
            down_reg      <= down_eval;
        end
        if (cmd.mul) begin
            prod_reg <= NUM_W'(d_reg) * NUM_W'(mul_t_reg);
        end
    end

    itse_div #(
        .QUO_W (SW),
        .DEN_W (CFG_TIME_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (den_reg),
        .quo     (quo),
        .done    (div_done)
    );

    assign scale_fin = !need_div_reg ? scale_res_reg :
                       down_reg ? (base_reg - quo) : (base_reg + quo);

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_data_reg.force_z       <= force_res_reg;
            m_data_reg.damping_scale <= SCALE_OUT_W'(scale_fin);
            m_data_reg.busy_res      <= busy_res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.need_div = need_div_eval;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ===== hw/rtl/itse_ctrl.sv =====
// ----------------------------------------------------------------------------
// itse_ctrl: envelope controller
// Sequences one item through step, evaluate, optional multiply and divide,
// and the hand-off into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output itse_pkg::dp_cmd_t    cmd,
    input  itse_pkg::dp_status_t status
);
    import itse_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_STEP = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_LOAD = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register can take the transfer
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/impulse_or_trapezoid_scale_envelope.sv =====
// ----------------------------------------------------------------------------
// impulse_or_trapezoid_scale_envelope: triggered force / damping envelope
// Flow: an input item passes the step and evaluate states, then the output
//   state loads the result register; on a ramp slope the multiply, divider
//   load and divide states come before the output state. No new item is
//   taken until the current one is through; the divider yields one quotient
//   bit per cycle. A result held by the receiver stalls the next one.
// Reset (aresetn low, synchronous): idle, elapsed time zero, registers at
//   their defaults, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module impulse_or_trapezoid_scale_envelope #(
    parameter int TIME_BITS       = 24,
    parameter int SCALE_FRAC_BITS = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  itse_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output itse_pkg::out_item_t              m_data
);
    import itse_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration writes are always accepted and registered straight into their registers
    assign cfg_ready = 1'b1;

    itse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    itse_dp #(
        .TIME_BITS       (TIME_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
